// ===== rtl/cbm_pkg.sv =====
// shared constants and types for the cartridge rom bank mapper
`timescale 1ns / 1ps

package cbm_pkg;

  // bus access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // configuration register indexes
  localparam logic CFG_BANK_COUNT   = 1'b0;
  localparam logic CFG_SRAM_PRESENT = 1'b1;

  // sizes
  localparam int ROM_BANK_BYTES       = 16384;
  localparam int ROM_OFF_W            = $clog2(ROM_BANK_BYTES);
  localparam int ROM_BANK_W           = 5;
  localparam int ROM_INDEX_W          = 19;
  localparam int RAM_OFF_W            = 13;
  localparam int DEF_RAM_WINDOW_BYTES = 8192;

  // reset values and fixed codes
  localparam logic [7:0]            BANK_COUNT_RST = 8'd2;
  localparam logic [ROM_BANK_W-1:0] ROM_BANK_RST   = 5'd1;
  localparam logic [3:0]            RAM_KEY        = 4'hA;
  localparam logic [7:0]            OPEN_BUS       = 8'hFF;
  localparam logic [2:0]            RAM_REGION     = 3'b101;

  // decoded outcome of one request, carried alongside the ram read
  typedef struct packed {
    logic                   rom_fetch;
    logic [ROM_INDEX_W-1:0] rom_index;
    logic                   ram_rd;
  } cbm_res_t;

endpackage

// ===== rtl/cbm_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module cbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/cbm_ctrl.sv =====
// mapper registers, address decode and ram access generation
`timescale 1ns / 1ps

module cbm_ctrl import cbm_pkg::*; #(
  parameter int RAM_WINDOW_BYTES = DEF_RAM_WINDOW_BYTES,
  parameter int RAM_AW           = $clog2(RAM_WINDOW_BYTES)
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration writes
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  // accepted request
  input  logic              req_fire,
  input  logic              operation,
  input  logic [15:0]       address,
  input  logic [7:0]        write_data,
  // decoded outcome
  output cbm_res_t          res,
  // ram access
  output logic              ram_we,
  output logic [RAM_AW-1:0] ram_addr
);

  logic [7:0]            bank_count_r;
  logic                  sram_present_r;
  logic                  ram_enable_r;
  logic [ROM_BANK_W-1:0] rom_bank_r;
  logic                  ram_enable_nxt;
  logic [ROM_BANK_W-1:0] rom_bank_nxt;
  logic [7:0]            bank_mask;
  logic [ROM_BANK_W-1:0] bank_wr;
  logic [ROM_BANK_W-1:0] bank_sel;
  logic                  in_ram_region;
  logic                  ram_ok;
  logic [RAM_OFF_W-1:0]  ram_off;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_count_r   <= BANK_COUNT_RST;
      sram_present_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BANK_COUNT:   bank_count_r   <= cfg_data;
        CFG_SRAM_PRESENT: sram_present_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ram window decode
  assign ram_off       = address[RAM_OFF_W-1:0];
  assign in_ram_region = (address[15:13] == RAM_REGION);
  assign ram_ok        = ram_enable_r && sram_present_r &&
                         ({1'b0, ram_off} < (RAM_OFF_W+1)'(RAM_WINDOW_BYTES));
  assign ram_addr      = ram_off[RAM_AW-1:0];

  // bank select write value, zero maps to one
  assign bank_mask = bank_count_r - 8'd1;
  assign bank_wr   = write_data[ROM_BANK_W-1:0] & bank_mask[ROM_BANK_W-1:0];

  // mapper register updates on writes
  always_comb begin
    ram_enable_nxt = ram_enable_r;
    rom_bank_nxt   = rom_bank_r;
    if (req_fire && operation == OP_WRITE) begin
      unique case (address[15:13])
        3'b000: ram_enable_nxt = (write_data[3:0] == RAM_KEY);
        3'b001: rom_bank_nxt   = (bank_wr == '0) ? ROM_BANK_RST : bank_wr;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_enable_r <= 1'b0;
      rom_bank_r   <= ROM_BANK_RST;
    end else begin
      ram_enable_r <= ram_enable_nxt;
      rom_bank_r   <= rom_bank_nxt;
    end
  end

  assign ram_we = req_fire && operation == OP_WRITE && in_ram_region && ram_ok;

  // read outcome: rom index is bank and offset, in range when bank below count
  assign bank_sel = address[14] ? rom_bank_r : '0;

  always_comb begin
    res = '0;
    if (operation == OP_READ) begin
      if (!address[15]) begin
        if ({3'b000, bank_sel} < bank_count_r) begin
          res.rom_fetch = 1'b1;
          res.rom_index = {bank_sel, address[ROM_OFF_W-1:0]};
        end
      end else if (in_ram_region) begin
        res.ram_rd = ram_ok;
      end
    end
  end

endmodule

// ===== rtl/cartridge_rom_bank_mapper.sv =====
// results: an accepted request is registered in stage 1 and then in the output register
// throughput: one request per cycle, unless the output stalls or the clearing pass runs
// reads and writes of the same ram byte in consecutive requests see each other in order
// reset: synchronous active low; rom bank 1, ram locked, bank count 2, no sram
// after reset a clearing pass zeroes the ram, with in_ready low until it is done
`timescale 1ns / 1ps

module cartridge_rom_bank_mapper import cbm_pkg::*; #(
  parameter int RAM_WINDOW_BYTES = DEF_RAM_WINDOW_BYTES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration port
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [0:0]             cfg_index,
  input  logic [7:0]             cfg_data,
  // request channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_operation,
  input  logic [15:0]            in_address,
  input  logic [7:0]             in_write_data,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_read_data,
  output logic                   out_rom_fetch,
  output logic [ROM_INDEX_W-1:0] out_rom_index
);

  localparam int RAM_AW = $clog2(RAM_WINDOW_BYTES);

  logic              req_fire;
  logic              s1_adv;
  logic              s1_valid_r;
  cbm_res_t          s1_res_r;
  cbm_res_t          res;
  logic              ctrl_we;
  logic [RAM_AW-1:0] ctrl_addr;
  logic              clr_busy_r;
  logic [RAM_AW-1:0] clr_addr_r;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_q;
  logic              out_valid_r;
  logic [7:0]        out_read_data_r;
  logic              out_rom_fetch_r;
  logic [ROM_INDEX_W-1:0] out_rom_index_r;

  assign cfg_ready = 1'b1;

  // handshake control
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clr_busy_r && (!s1_valid_r || s1_adv);
  assign req_fire = in_valid && in_ready;

  cbm_ctrl #(
    .RAM_WINDOW_BYTES(RAM_WINDOW_BYTES),
    .RAM_AW          (RAM_AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_fire  (req_fire),
    .operation (in_operation),
    .address   (in_address),
    .write_data(in_write_data),
    .res       (res),
    .ram_we    (ctrl_we),
    .ram_addr  (ctrl_addr)
  );

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + RAM_AW'(1);
      if (clr_addr_r == RAM_AW'(RAM_WINDOW_BYTES - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // ram write mux: clearing pass or request
  assign ram_we    = clr_busy_r || ctrl_we;
  assign ram_waddr = clr_busy_r ? clr_addr_r : ctrl_addr;
  assign ram_wdata = clr_busy_r ? 8'h00 : in_write_data;

  cbm_ram #(
    .WIDTH(8),
    .DEPTH(RAM_WINDOW_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (req_fire),
    .raddr(ctrl_addr),
    .rdata(ram_q)
  );

  // stage 1: request decoded, ram read in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (req_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_res_r <= res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_read_data_r <= s1_res_r.ram_rd ? ram_q : OPEN_BUS;
      out_rom_fetch_r <= s1_res_r.rom_fetch;
      out_rom_index_r <= s1_res_r.rom_index;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_rom_fetch = out_rom_fetch_r;
  assign out_rom_index = out_rom_index_r;

  // no request is taken while the ram is being cleared
  a_clr_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ready)
    else $error("request accepted during clearing pass");

  // a stalled stage 1 keeps its request
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_res_r)))
    else $error("stage 1 request lost under stall");

  // rom fetch results carry open bus data
  a_fetch_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rom_fetch_r) |-> (out_read_data_r == OPEN_BUS))
    else $error("rom fetch with ram data");

  // no fetch means a zero rom index
  a_nofetch_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rom_fetch_r) |-> (out_rom_index_r == '0))
    else $error("rom index without fetch");

endmodule

// ===== tb/tb_top.sv =====
// testbench for the cartridge rom bank mapper: directed table, then random bus traffic
`timescale 1ns / 1ps

module tb_top import cbm_pkg::*; ();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 160;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 8;

  // bank counts and sram presence set before each random phase; phase 6 takes a random bank count instead
  localparam logic [7:0] PHASE_BANKS [PHASES] = '{8'd16, 8'd128, 8'd255, 8'd0,
                                                  8'd1, 8'd32, 8'd2, 8'd8};
  localparam logic PHASE_SRAM [PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0,
                                           1'b1, 1'b1, 1'b1, 1'b1};

  typedef struct packed {
    logic [7:0]             read_data;
    logic                   rom_fetch;
    logic [ROM_INDEX_W-1:0] rom_index;
  } bus_result_t;

  typedef enum logic {ROW_REQUEST, ROW_REG_WRITE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        typed;
    bus_result_t want;
    logic        reg_idx;
    logic [7:0]  reg_val;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [0:0]             cfg_index = '0;
  logic [7:0]             cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_operation = OP_READ;
  logic [15:0]            in_address = '0;
  logic [7:0]             in_write_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [7:0]             out_read_data;
  logic                   out_rom_fetch;
  logic [ROM_INDEX_W-1:0] out_rom_index;

  // mapper state as the predictor sees it
  logic [7:0]            bank_count;
  logic                  sram_on;
  logic                  ram_on;
  logic [ROM_BANK_W-1:0] cur_bank;
  logic [7:0]            cart_ram [DEF_RAM_WINDOW_BYTES];

  bus_result_t pending_results [$];
  stim_row_t   stim_table [$];
  int          errors = 0;
  int          cycles = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  logic        long_hold_req = 1'b0;

  cartridge_rom_bank_mapper dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data),
    .out_rom_fetch (out_rom_fetch),
    .out_rom_index (out_rom_index)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // predicted result of one bus access, updating the mapper state
  function automatic bus_result_t map_access(logic op, logic [15:0] addr, logic [7:0] data);
    bus_result_t           r;
    logic [7:0]            mask;
    logic [ROM_BANK_W-1:0] sel;
    int unsigned           phys;
    int unsigned           rom_size;
    int unsigned           off;
    r = '{read_data: OPEN_BUS, rom_fetch: 1'b0, rom_index: '0};
    off = int'(addr) - 'hA000;
    if (op == OP_WRITE) begin
      if (addr <= 16'h1FFF) begin
        ram_on = (data[3:0] == RAM_KEY);
      end else if (addr <= 16'h3FFF) begin
        mask = bank_count - 8'd1;
        sel = data[4:0] & mask[4:0];
        cur_bank = (sel == '0) ? ROM_BANK_W'(1) : sel;
      end else if (addr >= 16'hA000 && addr <= 16'hBFFF) begin
        if (ram_on && sram_on && off < DEF_RAM_WINDOW_BYTES) cart_ram[off] = data;
      end
    end else begin
      if (addr < 16'h8000) begin
        rom_size = int'(bank_count) * ROM_BANK_BYTES;
        if (addr < 16'h4000) phys = int'(addr);
        else phys = int'(cur_bank) * ROM_BANK_BYTES + (int'(addr) - 'h4000);
        if (phys < rom_size) begin
          r.rom_fetch = 1'b1;
          r.rom_index = phys[ROM_INDEX_W-1:0];
        end
      end else if (addr >= 16'hA000 && addr <= 16'hBFFF) begin
        if (ram_on && sram_on && off < DEF_RAM_WINDOW_BYTES) r.read_data = cart_ram[off];
      end
    end
    return r;
  endfunction

  function automatic void add_req(logic op, logic [15:0] addr, logic [7:0] data,
                                  logic typed, bus_result_t want);
    stim_row_t row;
    row = '{kind: ROW_REQUEST, op: op, addr: addr, data: data, typed: typed,
            want: want, reg_idx: 1'b0, reg_val: 8'd0};
    stim_table.push_back(row);
  endfunction

  function automatic void add_reg(logic idx, logic [7:0] val);
    stim_row_t row;
    row = '{kind: ROW_REG_WRITE, op: OP_READ, addr: 16'd0, data: 8'd0, typed: 1'b0,
            want: '0, reg_idx: idx, reg_val: val};
    stim_table.push_back(row);
  endfunction

  // register write, predictor follows at the handshake
  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_BANK_COUNT) bank_count = val;
    else sram_on = val[0];
  endtask

  // lower valid and wait until every pending result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // one request with optional idle gap ahead of it
  task automatic issue_request(logic op, logic [15:0] addr, logic [7:0] data,
                               logic typed, bus_result_t want);
    bus_result_t pred;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_address    <= addr;
    in_write_data <= data;
    do @(posedge clk); while (!in_ready);
    pred = map_access(op, addr, data);
    pending_results.push_back(typed ? want : pred);
  endtask

  // result checking and receiver stalls
  always @(posedge clk) begin : rx_side
    bus_result_t want;
    static int   hold_left = 0;
    static logic hold_done = 1'b0;
    if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: read_data %0h rom_fetch %0b rom_index %0h",
               out_read_data, out_rom_fetch, out_rom_index);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_read_data !== want.read_data) begin
          $error("read_data: expected %0h, got %0h", want.read_data, out_read_data);
          errors++;
        end
        if (out_rom_fetch !== want.rom_fetch) begin
          $error("rom_fetch: expected %0b, got %0b", want.rom_fetch, out_rom_fetch);
          errors++;
        end
        if (out_rom_index !== want.rom_index) begin
          $error("rom_index: expected %0h, got %0h", want.rom_index, out_rom_index);
          errors++;
        end
      end
    end
    // one long hold-off so the block backs up into its input
    if (long_hold_req && !hold_done) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin : stimulus
    stim_row_t   row;
    logic [7:0]  banks;
    logic        sram;
    logic        op;
    logic [15:0] addr;
    logic [7:0]  data;
    int          pick;

    bank_count = BANK_COUNT_RST;
    sram_on    = 1'b0;
    ram_on     = 1'b0;
    cur_bank   = ROM_BANK_RST;
    foreach (cart_ram[i]) cart_ram[i] = 8'h00;

    // directed rows: reset state, region edges, lock and unlock, bank masking
    add_req(OP_READ,  16'h0000, 8'h00, 1'b1, {OPEN_BUS, 1'b1, 19'h00000});
    add_req(OP_READ,  16'h3FFF, 8'hFF, 1'b1, {OPEN_BUS, 1'b1, 19'h03FFF});
    add_req(OP_READ,  16'h4000, 8'h00, 1'b1, {OPEN_BUS, 1'b1, 19'h04000});
    add_req(OP_READ,  16'h7FFF, 8'hFF, 1'b1, {OPEN_BUS, 1'b1, 19'h07FFF});
    add_req(OP_READ,  16'hA000, 8'h00, 1'b1, {OPEN_BUS, 1'b0, 19'h0});
    add_req(OP_READ,  16'h8000, 8'h00, 1'b1, {OPEN_BUS, 1'b0, 19'h0});
    add_req(OP_READ,  16'hFFFF, 8'hFF, 1'b1, {OPEN_BUS, 1'b0, 19'h0});
    add_req(OP_WRITE, 16'h0000, 8'h0A, 1'b1, {OPEN_BUS, 1'b0, 19'h0});
    add_req(OP_WRITE, 16'hA000, 8'h55, 1'b1, {OPEN_BUS, 1'b0, 19'h0});
    add_req(OP_READ,  16'hA000, 8'h00, 1'b1, {OPEN_BUS, 1'b0, 19'h0});
    add_reg(CFG_SRAM_PRESENT, 8'd1);
    add_req(OP_WRITE, 16'hBFFF, 8'hA5, 1'b1, {OPEN_BUS, 1'b0, 19'h0});
    add_req(OP_READ,  16'hBFFF, 8'h00, 1'b0, '0);
    add_req(OP_READ,  16'hA000, 8'h00, 1'b0, '0);
    add_req(OP_WRITE, 16'h1FFF, 8'h0B, 1'b1, {OPEN_BUS, 1'b0, 19'h0});
    add_req(OP_READ,  16'hBFFF, 8'h00, 1'b1, {OPEN_BUS, 1'b0, 19'h0});
    add_req(OP_WRITE, 16'h1000, 8'hFA, 1'b1, {OPEN_BUS, 1'b0, 19'h0});
    add_req(OP_WRITE, 16'h2000, 8'h00, 1'b1, {OPEN_BUS, 1'b0, 19'h0});
    add_reg(CFG_BANK_COUNT, 8'd128);
    add_req(OP_WRITE, 16'h3FFF, 8'hFF, 1'b1, {OPEN_BUS, 1'b0, 19'h0});
    add_req(OP_READ,  16'h7FFF, 8'h00, 1'b0, '0);
    add_req(OP_WRITE, 16'h2FFF, 8'h20, 1'b1, {OPEN_BUS, 1'b0, 19'h0});
    add_req(OP_READ,  16'h4000, 8'h00, 1'b0, '0);
    add_reg(CFG_BANK_COUNT, 8'd0);
    add_req(OP_READ,  16'h0000, 8'h00, 1'b1, {OPEN_BUS, 1'b0, 19'h0});
    add_reg(CFG_BANK_COUNT, 8'd1);
    add_req(OP_READ,  16'h3FFF, 8'h00, 1'b0, '0);
    add_req(OP_READ,  16'h4000, 8'h00, 1'b0, '0);
    add_reg(CFG_BANK_COUNT, 8'd255);
    add_req(OP_WRITE, 16'h2000, 8'h1E, 1'b1, {OPEN_BUS, 1'b0, 19'h0});
    add_req(OP_READ,  16'h5555, 8'h00, 1'b0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.kind == ROW_REG_WRITE) begin
        drain_results();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        issue_request(row.op, row.addr, row.data, row.typed, row.want);
      end
    end

    // random phases, each with its own setting; the idle mix repeats every four phases
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      banks = (p == 6) ? 8'($urandom_range(255)) : PHASE_BANKS[p];
      sram  = PHASE_SRAM[p];
      write_reg(CFG_BANK_COUNT, banks);
      write_reg(CFG_SRAM_PRESENT, {7'd0, sram});
      case (p % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = 69;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 69;
        end
        default: begin
          tx_idle_pct = 13;
          rx_stall_pct = 13;
        end
      endcase
      if (p == 4) long_hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        data = 8'($urandom_range(255));
        op   = OP_READ;
        if (pick < 30) begin
          // rom reads across both windows
          addr = 16'($urandom_range(16'h7FFF));
        end else if (pick < 40) begin
          // bank select
          op   = OP_WRITE;
          addr = 16'h2000 + 16'($urandom_range(16'h1FFF));
        end else if (pick < 48) begin
          // ram enable, mostly with the unlock key
          op   = OP_WRITE;
          addr = 16'($urandom_range(16'h1FFF));
          if ($urandom_range(3) != 0) data[3:0] = RAM_KEY;
        end else if (pick < 82) begin
          // ram traffic, often on a few hot bytes so reads see earlier writes
          op = (pick < 64) ? OP_WRITE : OP_READ;
          if ($urandom_range(1) == 0)
            addr = 16'hA000 + 16'($urandom_range(15)) + ($urandom_range(1) ? 16'h1FF0 : 16'h0);
          else
            addr = 16'hA000 + 16'($urandom_range(16'h1FFF));
        end else if (pick < 92) begin
          // unmapped space
          op   = 1'($urandom_range(1));
          addr = $urandom_range(1) ? 16'h8000 + 16'($urandom_range(16'h1FFF))
                                   : 16'hC000 + 16'($urandom_range(16'h3FFF));
        end else begin
          op   = 1'($urandom_range(1));
          addr = 16'($urandom_range(16'hFFFF));
        end
        issue_request(op, addr, data, 1'b0, '0);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
